// ===== src/pbm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbm_pkg
// shared types, widths and helpers of the pixel blend datapath
// ----------------------------------------------------------------------------
`default_nettype none

package pbm_pkg;

   localparam int PIX_W = 8;
   localparam int NUM_W = 25;
   localparam int DEN_W = 17;
   localparam int QUO_W = 8;
   localparam int LANES = 3;
   localparam int DIV_STAGES = QUO_W;
   localparam logic [7:0] MAXV = 8'd255;
   localparam logic [7:0] HALF = 8'd128;

   // register slots, picked by paddr bit 2
   localparam logic CSR_IDX_MODE    = 1'b0;
   localparam logic CSR_IDX_OPACITY = 1'b1;

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_ADD      = 3'd1,
      MODE_SUB      = 3'd2,
      MODE_MULTIPLY = 3'd3,
      MODE_DODGE    = 3'd4,
      MODE_BURN     = 3'd5,
      MODE_SCREEN   = 3'd6,
      MODE_OVERLAY  = 3'd7
   } mode_type;

   // how a lane turns the quotient into its channel
   typedef enum logic [2:0] {
      FIN_FIXED  = 3'd0,
      FIN_QUOT   = 3'd1,
      FIN_ADD    = 3'd2,
      FIN_SUB_QA = 3'd3,
      FIN_SUB_QB = 3'd4,
      FIN_BURN   = 3'd5
   } fin_kind_type;

   typedef struct packed {
      fin_kind_type kind;
      logic [7:0]   val;
   } fin_type;

   // per pixel weights shared by all lanes
   typedef struct packed {
      logic [15:0] p;
      logic [15:0] w;
      logic [16:0] t;
      logic [7:0]  sa;
      logic [7:0]  da;
      logic [7:0]  sa_raw;
   } wgt_type;

   // floor(x / 255) via reciprocal and one correction step
   function automatic logic [9:0] div255(input logic [17:0] x);
      logic [26:0] prod;
      logic [10:0] q0;
      logic [18:0] qm;
      logic [18:0] r;
      prod = 27'(x) * 27'd257;
      q0   = prod[26:16];
      qm   = {q0, 8'b0} - {8'b0, q0};
      r    = 19'(x) - qm;
      if (r >= 19'd255) begin
         q0 = q0 + 11'd1;
      end
      return q0[9:0];
   endfunction

   function automatic logic [7:0] sat_hi(input logic [9:0] v);
      return (v > 10'd255) ? 8'd255 : v[7:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/pbm_div.sv =====
// ----------------------------------------------------------------------------
// pbm_div
// pipelined restoring divider, one quotient bit per stage, 8-bit quotient
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_div (
   input  wire logic                      clock,
   input  wire logic [pbm_pkg::NUM_W-1:0] num,
   input  wire logic [pbm_pkg::DEN_W-1:0] den,
   input  wire pbm_pkg::fin_type          fin_i,
   output logic [pbm_pkg::QUO_W-1:0]      quo,
   output pbm_pkg::fin_type               fin_o
);

   localparam int N = pbm_pkg::DIV_STAGES;

   logic [pbm_pkg::NUM_W-1:0] rem_ff [N];
   logic [pbm_pkg::DEN_W-1:0] den_ff [N];
   logic [pbm_pkg::QUO_W-1:0] quo_ff [N];
   logic                      ovf_ff [N];
   pbm_pkg::fin_type          fin_ff [N];

   logic [pbm_pkg::NUM_W-1:0] rem_in [N];
   logic [pbm_pkg::QUO_W-1:0] quo_in [N];
   logic                      ovf_in0;

   // quotient would not fit in 8 bits
   assign ovf_in0 = (num >= {den, 8'b0});

   for (genvar j = 0; j < N; j++) begin : g_stage
      localparam int K = pbm_pkg::QUO_W - 1 - j;
      logic [pbm_pkg::NUM_W-1:0] rem_cur;
      logic [pbm_pkg::DEN_W-1:0] den_cur;
      logic [pbm_pkg::QUO_W-1:0] quo_cur;
      logic                      ovf_cur;
      pbm_pkg::fin_type          fin_cur;
      logic [pbm_pkg::NUM_W-1:0] trial;

      if (j == 0) begin : g_first
         assign rem_cur = num;
         assign den_cur = den;
         assign quo_cur = '0;
         assign ovf_cur = ovf_in0;
         assign fin_cur = fin_i;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign den_cur = den_ff[j-1];
         assign quo_cur = quo_ff[j-1];
         assign ovf_cur = ovf_ff[j-1];
         assign fin_cur = fin_ff[j-1];
      end

      assign trial = pbm_pkg::NUM_W'(den_cur) << K;

      always_comb begin
         rem_in[j] = rem_cur;
         quo_in[j] = quo_cur;
         if (rem_cur >= trial) begin
            rem_in[j]    = rem_cur - trial;
            quo_in[j][K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in[j];
         den_ff[j] <= den_cur;
         quo_ff[j] <= quo_in[j];
         ovf_ff[j] <= ovf_cur;
         fin_ff[j] <= fin_cur;
      end
   end

   assign quo   = ovf_ff[N-1] ? '1 : quo_ff[N-1];
   assign fin_o = fin_ff[N-1];

endmodule

`default_nettype wire

// ===== src/pbm_lane.sv =====
// ----------------------------------------------------------------------------
// pbm_lane
// one color channel: premultiply, mode math, divider, final saturation
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_lane (
   input  wire logic              clock,
   input  wire pbm_pkg::mode_type mode,
   input  wire logic [7:0]        d1,
   input  wire logic [7:0]        s1,
   input  wire logic [7:0]        da1,
   input  wire logic [7:0]        sa1,
   input  wire pbm_pkg::wgt_type  wgt4,
   input  wire pbm_pkg::wgt_type  wgt5,
   output logic [7:0]             chan
);

   // stage 2
   logic [15:0] dprod_ff, sprod_ff;
   logic [7:0]  d2_ff, s2_ff;
   // stage 3
   logic [7:0]  dp3_ff, sp3_ff, d3_ff, s3_ff;
   // stage 4
   logic [15:0] x4_ff, y4_ff;
   logic [7:0]  dp4_ff, sp4_ff, d4_ff, s4_ff;
   // stage 5
   logic [23:0] na5_ff, nb5_ff;
   logic [15:0] dq5_ff;
   logic [7:0]  x255_ff, y255_ff, ovlo_ff;
   logic [7:0]  dp5_ff, sp5_ff, d5_ff, s5_ff;
   // stage 6, divider input
   logic [pbm_pkg::NUM_W-1:0] num_ff, num_in;
   logic [pbm_pkg::DEN_W-1:0] den_ff, den_in;
   pbm_pkg::fin_type          fin6_ff, fin6_in;

   logic [7:0]  ndp, nsp;
   logic [15:0] dq_in;
   logic [9:0]  ov_sum, ov_hi;
   logic [9:0]  dp_q, sp_q, x_q, y_q;

   logic [pbm_pkg::QUO_W-1:0] quo;
   pbm_pkg::fin_type          fin_q;
   logic [8:0]                add9;

   assign ndp = pbm_pkg::MAXV - dp3_ff;
   assign nsp = pbm_pkg::MAXV - sp3_ff;

   // premultiply and product scaling by 255
   assign dp_q = pbm_pkg::div255({2'b0, dprod_ff});
   assign sp_q = pbm_pkg::div255({2'b0, sprod_ff});
   assign x_q  = pbm_pkg::div255({2'b0, x4_ff});
   assign y_q  = pbm_pkg::div255({2'b0, y4_ff});

   // add and sub: scale whichever side has the smaller alpha
   assign dq_in = (wgt4.da > wgt4.sa) ? (16'(s4_ff) * 16'(wgt4.sa))
                                      : (16'(d4_ff) * 16'(wgt4.da));

   always_ff @(posedge clock) begin
      dprod_ff <= 16'(d1) * 16'(da1);
      sprod_ff <= 16'(s1) * 16'(sa1);
      d2_ff    <= d1;
      s2_ff    <= s1;

      dp3_ff <= dp_q[7:0];
      sp3_ff <= sp_q[7:0];
      d3_ff  <= d2_ff;
      s3_ff  <= s2_ff;

      x4_ff  <= 16'(dp3_ff) * 16'(sp3_ff);
      y4_ff  <= 16'(ndp) * 16'(nsp);
      dp4_ff <= dp3_ff;
      sp4_ff <= sp3_ff;
      d4_ff  <= d3_ff;
      s4_ff  <= s3_ff;

      na5_ff  <= 24'(d4_ff) * 24'(wgt4.w);
      nb5_ff  <= 24'(s4_ff) * 24'(wgt4.p);
      dq5_ff  <= dq_in;
      x255_ff <= x_q[7:0];
      y255_ff <= y_q[7:0];
      ovlo_ff <= pbm_pkg::sat_hi(pbm_pkg::div255({1'b0, x4_ff, 1'b0}));
      dp5_ff  <= dp4_ff;
      sp5_ff  <= sp4_ff;
      d5_ff   <= d4_ff;
      s5_ff   <= s4_ff;

      num_ff  <= num_in;
      den_ff  <= den_in;
      fin6_ff <= fin6_in;
   end

   assign ov_sum = 10'(dp5_ff) + 10'(sp5_ff) - 10'(x255_ff);
   assign ov_hi  = {ov_sum[8:0], 1'b0} - 10'd255;

   always_comb begin
      num_in       = '0;
      den_in       = pbm_pkg::DEN_W'(1);
      fin6_in.kind = pbm_pkg::FIN_FIXED;
      fin6_in.val  = d5_ff;
      unique case (mode)
         pbm_pkg::MODE_NORMAL: begin
            if (wgt5.p < 16'd255) begin
               fin6_in.val = d5_ff;
            end else if (wgt5.w == 16'd0) begin
               fin6_in.val = s5_ff;
            end else begin
               num_in       = pbm_pkg::NUM_W'(na5_ff) + pbm_pkg::NUM_W'(nb5_ff);
               den_in       = wgt5.t;
               fin6_in.kind = pbm_pkg::FIN_QUOT;
            end
         end
         pbm_pkg::MODE_ADD, pbm_pkg::MODE_SUB: begin
            if (wgt5.sa == 8'd0) begin
               fin6_in.val = d5_ff;
            end else if (wgt5.da == wgt5.sa) begin
               num_in       = pbm_pkg::NUM_W'(d5_ff);
               fin6_in.val  = s5_ff;
               fin6_in.kind = (mode == pbm_pkg::MODE_SUB) ? pbm_pkg::FIN_SUB_QA
                                                          : pbm_pkg::FIN_ADD;
            end else if (wgt5.da > wgt5.sa) begin
               num_in       = pbm_pkg::NUM_W'(dq5_ff);
               den_in       = pbm_pkg::DEN_W'(wgt5.da);
               fin6_in.val  = d5_ff;
               fin6_in.kind = (mode == pbm_pkg::MODE_SUB) ? pbm_pkg::FIN_SUB_QB
                                                          : pbm_pkg::FIN_ADD;
            end else begin
               num_in       = pbm_pkg::NUM_W'(dq5_ff);
               den_in       = pbm_pkg::DEN_W'(wgt5.sa);
               fin6_in.val  = s5_ff;
               fin6_in.kind = (mode == pbm_pkg::MODE_SUB) ? pbm_pkg::FIN_SUB_QA
                                                          : pbm_pkg::FIN_ADD;
            end
         end
         pbm_pkg::MODE_MULTIPLY: begin
            fin6_in.val = x255_ff;
         end
         pbm_pkg::MODE_DODGE: begin
            if (sp5_ff == pbm_pkg::MAXV) begin
               fin6_in.val = pbm_pkg::MAXV;
            end else begin
               num_in       = pbm_pkg::NUM_W'({dp5_ff, 8'b0} - {8'b0, dp5_ff});
               den_in       = pbm_pkg::DEN_W'(pbm_pkg::MAXV - sp5_ff);
               fin6_in.kind = pbm_pkg::FIN_QUOT;
            end
         end
         pbm_pkg::MODE_BURN: begin
            if (sp5_ff == 8'd0) begin
               fin6_in.val = 8'd0;
            end else begin
               num_in = pbm_pkg::NUM_W'({pbm_pkg::MAXV - dp5_ff, 8'b0}
                                        - {8'b0, pbm_pkg::MAXV - dp5_ff});
               den_in       = pbm_pkg::DEN_W'(sp5_ff);
               fin6_in.kind = pbm_pkg::FIN_BURN;
            end
         end
         pbm_pkg::MODE_SCREEN: begin
            fin6_in.val = pbm_pkg::MAXV - y255_ff;
         end
         pbm_pkg::MODE_OVERLAY: begin
            fin6_in.val = (dp5_ff < pbm_pkg::HALF) ? ovlo_ff : pbm_pkg::sat_hi(ov_hi);
         end
         default: begin
            fin6_in.val = d5_ff;
         end
      endcase
   end

   pbm_div u_div (
      .clock (clock),
      .num   (num_ff),
      .den   (den_ff),
      .fin_i (fin6_ff),
      .quo   (quo),
      .fin_o (fin_q)
   );

   assign add9 = 9'(quo) + 9'(fin_q.val);

   always_comb begin
      case (fin_q.kind)
         pbm_pkg::FIN_QUOT:   chan = quo;
         pbm_pkg::FIN_ADD:    chan = add9[8] ? 8'd255 : add9[7:0];
         pbm_pkg::FIN_SUB_QA: chan = (quo >= fin_q.val) ? quo - fin_q.val : 8'd0;
         pbm_pkg::FIN_SUB_QB: chan = (fin_q.val >= quo) ? fin_q.val - quo : 8'd0;
         pbm_pkg::FIN_BURN:   chan = pbm_pkg::MAXV - quo;
         default:             chan = fin_q.val;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/pixel_blend_modes_core.sv =====
// ----------------------------------------------------------------------------
// pixel_blend_modes_core
// rgba blend of a source pixel onto a destination pixel, eight modes
// ----------------------------------------------------------------------------
// throughput: one pixel word per clock, busy stays low; three color lanes
//   each hold a six stage front end and an eight stage divider pipeline
// the receiver cannot stall: each result is shown for one cycle only
// reset (synchronous): pipeline emptied, blend_mode 0, opacity 255
`default_nettype none

module pixel_blend_modes_core (
   input  wire logic       clock,
   input  wire logic       reset,
   // input word
   input  wire logic       start,
   output logic            busy,
   input  wire logic [7:0] req_dst_red,
   input  wire logic [7:0] req_dst_green,
   input  wire logic [7:0] req_dst_blue,
   input  wire logic [7:0] req_dst_alpha,
   input  wire logic [7:0] req_src_red,
   input  wire logic [7:0] req_src_green,
   input  wire logic [7:0] req_src_blue,
   input  wire logic [7:0] req_src_alpha,
   // result word
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_red,
   output logic [7:0]      rsp_out_green,
   output logic [7:0]      rsp_out_blue,
   output logic [7:0]      rsp_out_alpha,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int DEPTH = 6 + pbm_pkg::DIV_STAGES;

   // ---------------- registers ----------------
   pbm_pkg::mode_type mode_ff;
   logic [7:0]        opacity_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= pbm_pkg::MODE_NORMAL;
         opacity_ff <= 8'd255;
      end else if (csr_wr) begin
         unique case (paddr[2])
            pbm_pkg::CSR_IDX_MODE:    mode_ff    <= pbm_pkg::mode_type'(pwdata[2:0]);
            pbm_pkg::CSR_IDX_OPACITY: opacity_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         pbm_pkg::CSR_IDX_MODE:    prdata = {29'b0, mode_ff};
         pbm_pkg::CSR_IDX_OPACITY: prdata = {24'b0, opacity_ff};
         default:                  prdata = '0;
      endcase
   end

   // ---------------- control: valid shift line ----------------
   // fully pipelined, so a word is taken every cycle
   logic             accept;
   logic [DEPTH-1:0] vld_ff;
   logic             rsp_valid_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[DEPTH-2:0], accept};
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- stage 1: capture the pixel pair ----------------
   logic [7:0] d1_ff [pbm_pkg::LANES];
   logic [7:0] s1_ff [pbm_pkg::LANES];
   logic [7:0] da1_ff, sa1_ff;

   always_ff @(posedge clock) begin
      d1_ff[0] <= req_dst_red;
      d1_ff[1] <= req_dst_green;
      d1_ff[2] <= req_dst_blue;
      s1_ff[0] <= req_src_red;
      s1_ff[1] <= req_src_green;
      s1_ff[2] <= req_src_blue;
      da1_ff   <= req_dst_alpha;
      sa1_ff   <= req_src_alpha;
   end

   // ---------------- shared weights ----------------
   // p = source alpha * opacity, sa = p / 255, w = dst alpha * (255 - sa)
   logic [15:0]      p2_ff, p3_ff;
   logic [7:0]       da2_ff, sa2_ff, da3_ff, sa3_ff, ps3_ff;
   logic [9:0]       ps_q;
   pbm_pkg::wgt_type wgt4_ff, wgt5_ff, wgt4_in, wgt5_in;

   assign ps_q = pbm_pkg::div255({2'b0, p2_ff});

   always_comb begin
      wgt4_in        = '0;
      wgt4_in.p      = p3_ff;
      wgt4_in.w      = 16'(da3_ff) * 16'(pbm_pkg::MAXV - ps3_ff);
      wgt4_in.sa     = ps3_ff;
      wgt4_in.da     = da3_ff;
      wgt4_in.sa_raw = sa3_ff;
      wgt5_in        = wgt4_ff;
      wgt5_in.t      = 17'(wgt4_ff.w) + 17'(wgt4_ff.p);
   end

   always_ff @(posedge clock) begin
      p2_ff   <= 16'(sa1_ff) * 16'(opacity_ff);
      da2_ff  <= da1_ff;
      sa2_ff  <= sa1_ff;
      p3_ff   <= p2_ff;
      ps3_ff  <= ps_q[7:0];
      da3_ff  <= da2_ff;
      sa3_ff  <= sa2_ff;
      wgt4_ff <= wgt4_in;
      wgt5_ff <= wgt5_in;
   end

   // ---------------- alpha path, then delay to match the divider ----------------
   logic [7:0] alpha_in;
   logic [7:0] alpha_ff [pbm_pkg::DIV_STAGES + 1];

   always_comb begin
      unique case (mode_ff)
         pbm_pkg::MODE_NORMAL: begin
            if (wgt5_ff.p < 16'd255) begin
               alpha_in = wgt5_ff.da;                 // faint source
            end else if (wgt5_ff.w == 16'd0) begin
               alpha_in = wgt5_ff.sa_raw;             // source copied
            end else begin
               alpha_in = pbm_pkg::sat_hi(pbm_pkg::div255({1'b0, wgt5_ff.t}));
            end
         end
         pbm_pkg::MODE_ADD, pbm_pkg::MODE_SUB: begin
            if (wgt5_ff.sa != 8'd0 && wgt5_ff.da < wgt5_ff.sa) begin
               alpha_in = wgt5_ff.sa;
            end else begin
               alpha_in = wgt5_ff.da;
            end
         end
         default: begin
            alpha_in = pbm_pkg::MAXV;                 // premultiplied modes
         end
      endcase
   end

   always_ff @(posedge clock) begin
      alpha_ff[0] <= alpha_in;
      for (int k = 1; k <= pbm_pkg::DIV_STAGES; k++) begin
         alpha_ff[k] <= alpha_ff[k-1];
      end
   end

   // ---------------- color lanes ----------------
   logic [7:0] chan [pbm_pkg::LANES];

   for (genvar i = 0; i < pbm_pkg::LANES; i++) begin : g_lane
      pbm_lane u_lane (
         .clock (clock),
         .mode  (mode_ff),
         .d1    (d1_ff[i]),
         .s1    (s1_ff[i]),
         .da1   (da1_ff),
         .sa1   (sa1_ff),
         .wgt4  (wgt4_ff),
         .wgt5  (wgt5_ff),
         .chan  (chan[i])
      );
   end

   // ---------------- merge: output register ----------------
   logic [7:0] out_r_ff, out_g_ff, out_b_ff, out_a_ff;

   always_ff @(posedge clock) begin
      out_r_ff <= chan[0];
      out_g_ff <= chan[1];
      out_b_ff <= chan[2];
      out_a_ff <= alpha_ff[pbm_pkg::DIV_STAGES];
   end

   assign rsp_out_red   = out_r_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_blue  = out_b_ff;
   assign rsp_out_alpha = out_a_ff;

   // ---------------- assertions ----------------
   // every accepted word comes out as a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##15 rsp_valid)
      else $error("accepted word not delivered after 15 cycles");

   // no result without a matching accepted word
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 15))
      else $error("result strobe without matching accepted word");

   // reset empties the pipeline
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

`default_nettype wire
